### hdl/strm_pkg.sv
package strm_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W        = $clog2(LEVELS);
  localparam int ADDR_W       = LVL_W + IDX_W;
  localparam int DEPTH        = LEVELS * MAX_ELEMENTS;
  localparam int DATA_W       = 32;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLD_RD_A,
    S_BLD_RD_B,
    S_BLD_WR,
    S_QRY_RD_A,
    S_QRY_RD_B,
    S_QRY_DONE
  } strm_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } strm_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } strm_rd_t;

  // Level-major layout: each level owns one aligned block of entries.
  function automatic logic [ADDR_W-1:0] table_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
    return {lvl, idx};
  endfunction

endpackage

### hdl/strm_ram.sv
module strm_ram (
  input  logic                           clk,
  input  strm_pkg::strm_wr_t             wr,
  input  strm_pkg::strm_rd_t             rd,
  output logic [strm_pkg::DATA_W-1:0]    rd_data
);

  logic [strm_pkg::DATA_W-1:0] mem [strm_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### hdl/sparse_table_range_min_top.sv
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+----------------------------
// input    | in_operation, in_element_value, in_element_last,| beat taken when start is high
//          | in_query_left, in_query_right                  | and busy is low
// result   | out_range_minimum, out_query_status            | beat shown for one cycle with
//          |                                                | out_valid; cannot be held off
//
// A load beat stores one element. The load beat flagged last then builds the table: for each
// element and level over the ten upper levels it reads the entry below and any partner,
// then writes the minimum, through the single read port of the table memory. A query beat
// does two table reads and one compare; a rejected query answers in the next cycle.
// Reset is synchronous and active low; it clears the count and the built flag, the
// table memory itself is left as it is. The result side cannot stall.
module sparse_table_range_min_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_operation,
  input  logic signed [strm_pkg::DATA_W-1:0]   in_element_value,
  input  logic                                 in_element_last,
  input  logic [strm_pkg::IDX_W-1:0]           in_query_left,
  input  logic [strm_pkg::IDX_W-1:0]           in_query_right,
  output logic                                 out_valid,
  output logic signed [strm_pkg::DATA_W-1:0]   out_range_minimum,
  output logic                                 out_query_status
);

  // Floor of log2 for a nonzero span; a narrow priority encoder.
  function automatic logic [strm_pkg::LVL_W-1:0] floor_log2(
      input logic [strm_pkg::CNT_W-1:0] v);
    logic [strm_pkg::LVL_W-1:0] k;
    k = '0;
    for (int b = 0; b < strm_pkg::CNT_W; b++) begin
      if (v[b]) begin
        k = strm_pkg::LVL_W'(b);
      end
    end
    return k;
  endfunction

  strm_pkg::strm_state_t state_r, state_nxt;

  logic [strm_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic                              built_r, built_nxt;
  logic [strm_pkg::LVL_W-1:0]        d_r, d_nxt;
  logic [strm_pkg::IDX_W-1:0]        i_r, i_nxt;
  logic [strm_pkg::IDX_W-1:0]        dist_r, dist_nxt;
  logic signed [strm_pkg::DATA_W-1:0] a_r, a_nxt;
  logic                              use_b_r, use_b_nxt;
  logic [strm_pkg::LVL_W-1:0]        k_r, k_nxt;
  logic [strm_pkg::IDX_W-1:0]        left_r, left_nxt;
  logic [strm_pkg::IDX_W-1:0]        second_r, second_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [strm_pkg::DATA_W-1:0] out_min_r, out_min_nxt;
  logic                              out_status_r, out_status_nxt;

  strm_pkg::strm_wr_t                wr;
  strm_pkg::strm_rd_t                rd;
  logic [strm_pkg::DATA_W-1:0]       rd_data;

  // The one shared compare unit: the first word held in a_r against the word
  // that the memory returns now. Both the build and the query pass use it.
  logic signed [strm_pkg::DATA_W-1:0] min_y;
  assign min_y = (a_r <= $signed(rd_data)) ? a_r : $signed(rd_data);

  logic [strm_pkg::CNT_W-1:0] eff_count;
  logic [strm_pkg::CNT_W-1:0] span;
  logic [strm_pkg::LVL_W-1:0] span_k;
  logic [strm_pkg::CNT_W-1:0] second_full;
  logic [strm_pkg::CNT_W-1:0] pair_idx;
  logic [strm_pkg::CNT_W-1:0] next_i;

  // A load after a finished build starts a fresh element list.
  assign eff_count   = built_r ? '0 : count_r;
  assign span        = {1'b0, in_query_right} - {1'b0, in_query_left} + strm_pkg::CNT_W'(1);
  assign span_k      = floor_log2(span);
  assign second_full = {1'b0, in_query_right} + strm_pkg::CNT_W'(1)
                       - (strm_pkg::CNT_W'(1) << span_k);
  assign pair_idx    = {1'b0, i_r} + {1'b0, dist_r};
  assign next_i      = {1'b0, i_r} + strm_pkg::CNT_W'(1);

  strm_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strm_pkg::S_IDLE;
      count_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r          <= d_nxt;
    i_r          <= i_nxt;
    dist_r       <= dist_nxt;
    a_r          <= a_nxt;
    use_b_r      <= use_b_nxt;
    k_r          <= k_nxt;
    left_r       <= left_nxt;
    second_r     <= second_nxt;
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    built_nxt      = built_r;
    d_nxt          = d_r;
    i_nxt          = i_r;
    dist_nxt       = dist_r;
    a_nxt          = a_r;
    use_b_nxt      = use_b_r;
    k_nxt          = k_r;
    left_nxt       = left_r;
    second_nxt     = second_r;
    out_valid_nxt  = 1'b0;
    out_min_nxt    = out_min_r;
    out_status_nxt = out_status_r;
    wr             = '0;
    rd             = '0;

    unique case (state_r)
      strm_pkg::S_IDLE: begin
        if (start) begin
          if (in_operation == strm_pkg::OP_LOAD) begin
            built_nxt = 1'b0;
            count_nxt = eff_count;
            // Elements past capacity are dropped, but a last flag still builds.
            if (eff_count < strm_pkg::CNT_W'(strm_pkg::MAX_ELEMENTS)) begin
              wr.en     = 1'b1;
              wr.addr   = strm_pkg::table_addr('0, eff_count[strm_pkg::IDX_W-1:0]);
              wr.data   = in_element_value;
              count_nxt = eff_count + strm_pkg::CNT_W'(1);
            end
            if (in_element_last) begin
              d_nxt     = strm_pkg::LVL_W'(1);
              i_nxt     = '0;
              dist_nxt  = strm_pkg::IDX_W'(1);
              state_nxt = strm_pkg::S_BLD_RD_A;
            end
          end else begin
            if (!built_r || (in_query_left > in_query_right) ||
                ({1'b0, in_query_right} >= count_r) ||
                (span_k >= strm_pkg::LVL_W'(strm_pkg::LEVELS))) begin
              out_valid_nxt  = 1'b1;
              out_min_nxt    = '0;
              out_status_nxt = strm_pkg::STATUS_ERR;
            end else begin
              k_nxt      = span_k;
              left_nxt   = in_query_left;
              second_nxt = second_full[strm_pkg::IDX_W-1:0];
              state_nxt  = strm_pkg::S_QRY_RD_A;
            end
          end
        end
      end

      strm_pkg::S_BLD_RD_A: begin
        rd.en     = 1'b1;
        rd.addr   = strm_pkg::table_addr(d_r - strm_pkg::LVL_W'(1), i_r);
        state_nxt = strm_pkg::S_BLD_RD_B;
      end

      strm_pkg::S_BLD_RD_B: begin
        a_nxt     = $signed(rd_data);
        // Entries near the end have no partner and copy the level below.
        use_b_nxt = (pair_idx < count_r);
        if (pair_idx < count_r) begin
          rd.en   = 1'b1;
          rd.addr = strm_pkg::table_addr(d_r - strm_pkg::LVL_W'(1),
                                         pair_idx[strm_pkg::IDX_W-1:0]);
        end
        state_nxt = strm_pkg::S_BLD_WR;
      end

      strm_pkg::S_BLD_WR: begin
        wr.en   = 1'b1;
        wr.addr = strm_pkg::table_addr(d_r, i_r);
        wr.data = use_b_r ? min_y : a_r;
        if (next_i == count_r) begin
          if (d_r == strm_pkg::LVL_W'(strm_pkg::LEVELS - 1)) begin
            built_nxt = 1'b1;
            state_nxt = strm_pkg::S_IDLE;
          end else begin
            d_nxt     = d_r + strm_pkg::LVL_W'(1);
            i_nxt     = '0;
            dist_nxt  = dist_r << 1;
            state_nxt = strm_pkg::S_BLD_RD_A;
          end
        end else begin
          i_nxt     = next_i[strm_pkg::IDX_W-1:0];
          state_nxt = strm_pkg::S_BLD_RD_A;
        end
      end

      strm_pkg::S_QRY_RD_A: begin
        rd.en     = 1'b1;
        rd.addr   = strm_pkg::table_addr(k_r, left_r);
        state_nxt = strm_pkg::S_QRY_RD_B;
      end

      strm_pkg::S_QRY_RD_B: begin
        a_nxt     = $signed(rd_data);
        rd.en     = 1'b1;
        rd.addr   = strm_pkg::table_addr(k_r, second_r);
        state_nxt = strm_pkg::S_QRY_DONE;
      end

      strm_pkg::S_QRY_DONE: begin
        out_valid_nxt  = 1'b1;
        out_min_nxt    = min_y;
        out_status_nxt = strm_pkg::STATUS_OK;
        state_nxt      = strm_pkg::S_IDLE;
      end

      default: begin
        state_nxt = strm_pkg::S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != strm_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_range_minimum = out_min_r;
  assign out_query_status  = out_status_r;

endmodule

### tb/tb.sv
module tb;

  // Roughly how many beats the random part sends, and a hard ceiling on the run.
  // The worst correct run, about 1800 beats with their idle gaps plus the builds for
  // every loaded element, stays well under this.
  localparam int ITEM_TARGET = 1800;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [strm_pkg::DATA_W-1:0] minimum;
    logic                               status;
  } rmq_answer_t;

  // Mirrors the engine's element store, count and built flag. It answers each
  // query by scanning the range directly. For any valid range that matches the
  // two overlapping sparse-table entries, so no table is kept here.
  class range_min_predictor;
    logic signed [strm_pkg::DATA_W-1:0] elements [strm_pkg::MAX_ELEMENTS];
    int unsigned                        held;
    bit                                 built;
    rmq_answer_t                        pending_answers[$];
    int                                 errors;

    function void note_beat(input logic op,
                            input logic signed [strm_pkg::DATA_W-1:0] value,
                            input logic is_last,
                            input logic [strm_pkg::IDX_W-1:0] left,
                            input logic [strm_pkg::IDX_W-1:0] right);
      rmq_answer_t ans;
      int unsigned span;
      int unsigned lvl;
      if (op == strm_pkg::OP_LOAD) begin
        if (built) begin
          built = 0;
          held  = 0;
        end
        if (held < strm_pkg::MAX_ELEMENTS) begin
          elements[held] = value;
          held++;
        end
        if (is_last) built = 1;
        return;
      end
      ans.status  = strm_pkg::STATUS_ERR;
      ans.minimum = '0;
      if (built && left <= right && right < held) begin
        span = right - left + 1;
        lvl  = 0;
        while (span > 1) begin
          span >>= 1;
          lvl++;
        end
        if (lvl < strm_pkg::LEVELS) begin
          ans.status  = strm_pkg::STATUS_OK;
          ans.minimum = elements[left];
          for (int i = left + 1; i <= right; i++)
            if (elements[i] < ans.minimum) ans.minimum = elements[i];
        end
      end
      pending_answers.push_back(ans);
    endfunction

    function void check_answer(input logic signed [strm_pkg::DATA_W-1:0] got_min,
                               input logic got_status);
      rmq_answer_t exp;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat, minimum %0d status %0d",
                 $time, got_min, got_status);
        errors++;
        return;
      end
      exp = pending_answers.pop_front();
      if (got_status !== exp.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, exp.status, got_status);
        errors++;
      end
      if (got_min !== exp.minimum) begin
        $display("%0t: minimum mismatch, expected %0d actual %0d",
                 $time, exp.minimum, got_min);
        errors++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               in_operation = strm_pkg::OP_LOAD;
  logic signed [strm_pkg::DATA_W-1:0] in_element_value = '0;
  logic                               in_element_last = 1'b0;
  logic [strm_pkg::IDX_W-1:0]         in_query_left = '0;
  logic [strm_pkg::IDX_W-1:0]         in_query_right = '0;
  logic                               out_valid;
  logic signed [strm_pkg::DATA_W-1:0] out_range_minimum;
  logic                               out_query_status;

  range_min_predictor rmq = new();

  // Stimulus-side view of the element count and built flag. The generator needs
  // these to aim queries at valid ranges before the beat is actually taken.
  int unsigned stim_count = 0;
  bit          stim_built = 0;
  int          beats_sent = 0;
  bit          burst = 0;
  int          cycles = 0;

  sparse_table_range_min_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_element_value  (in_element_value),
    .in_element_last   (in_element_last),
    .in_query_left     (in_query_left),
    .in_query_right    (in_query_right),
    .out_valid         (out_valid),
    .out_range_minimum (out_range_minimum),
    .out_query_status  (out_query_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Both monitors sample at the rising edge. They see the values from before
  // the edge, because the testbench and the engine update through nonblocking
  // assignments.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      rmq.note_beat(in_operation, in_element_value, in_element_last,
                    in_query_left, in_query_right);
    if (rst_n && out_valid)
      rmq.check_answer(out_range_minimum, out_query_status);
  end

  // A hang anywhere, such as a build that never ends or a lost result, lands here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one beat and returns at the edge that takes it. Start stays high
  // afterwards, so back-to-back beats never drop start within a step. In burst
  // stretches there is no idle gap. Otherwise about half the beats first wait a random
  // idle gap with start low.
  task automatic send_beat(input logic op,
                           input logic signed [strm_pkg::DATA_W-1:0] value,
                           input logic is_last,
                           input logic [strm_pkg::IDX_W-1:0] left,
                           input logic [strm_pkg::IDX_W-1:0] right);
    int gap;
    gap = (burst || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_operation     <= op;
    in_element_value <= value;
    in_element_last  <= is_last;
    in_query_left    <= left;
    in_query_right   <= right;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // The query fields of a load beat are don't-care, so they carry random bits.
  task automatic load_elem(input logic signed [strm_pkg::DATA_W-1:0] value,
                           input logic is_last);
    send_beat(strm_pkg::OP_LOAD, value, is_last, strm_pkg::IDX_W'($urandom),
              strm_pkg::IDX_W'($urandom));
    if (stim_built) begin
      stim_built = 0;
      stim_count = 0;
    end
    if (stim_count < strm_pkg::MAX_ELEMENTS) stim_count++;
    if (is_last) stim_built = 1;
  endtask

  task automatic ask(input logic [strm_pkg::IDX_W-1:0] left,
                     input logic [strm_pkg::IDX_W-1:0] right);
    send_beat(strm_pkg::OP_QUERY, strm_pkg::DATA_W'($urandom), 1'($urandom),
              left, right);
  endtask

  // The sender holds off until every expected result is in and the engine is
  // idle again.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (rmq.pending_answers.size() != 0 || busy);
  endtask

  // Mostly full-range random values. Clusters near both extremes and a narrow
  // band around zero are mixed in, so ties and sign handling get exercised.
  function automatic logic signed [strm_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000 + $urandom_range(0, 3);
      1:       return 32'sh7fff_ffff - $urandom_range(0, 3);
      2:       return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    int nq;
    int set_no;
    int big_at;
    int left;
    bit broken;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Queries come first, before any table exists.
    ask(0, 0);
    ask(1023, 1023);
    // A five-element set that holds both signed extremes, zero and minus one.
    load_elem(32'sh7fff_ffff, 0);
    load_elem(32'sh8000_0000, 0);
    load_elem(0, 0);
    load_elem(-1, 0);
    load_elem(1, 1);
    ask(0, 4);
    ask(0, 0);
    ask(4, 4);
    ask(0, 1);
    ask(2, 4);
    ask(3, 2);        // Left above right.
    ask(0, 5);        // Right one past the loaded count.
    ask(0, 1023);
    // A one-element table.
    load_elem(-5, 1);
    ask(0, 0);
    ask(0, 1);
    // Loading after a build drops the old table. Queries in between are rejected.
    load_elem(7, 0);
    load_elem(3, 0);
    ask(0, 0);
    load_elem(9, 1);
    ask(0, 2);
    ask(1, 2);
    drain();

    // Random part. Sets are mostly small, to keep the builds short. Exactly one
    // set fills the table past capacity; its extra elements must be discarded.
    // Some sets never see a last flag. Their queries must fail, and the next set
    // keeps appending to the same count.
    set_no = 0;
    big_at = $urandom_range(1, 4);
    while (beats_sent < ITEM_TARGET) begin
      set_no++;
      burst = ($urandom_range(0, 3) == 0);
      if (set_no == big_at) n = strm_pkg::MAX_ELEMENTS + 2;
      else if ($urandom_range(0, 15) == 0) n = $urandom_range(41, 120);
      else n = $urandom_range(1, 40);
      broken = (set_no != big_at) && ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
        if (broken && $urandom_range(0, 9) == 0)
          ask(strm_pkg::IDX_W'($urandom), strm_pkg::IDX_W'($urandom));
        load_elem(pick_value(), !broken && i == n - 1);
      end
      nq = (set_no == big_at) ? 40 : $urandom_range(4, 20);
      for (int q = 0; q < nq; q++) begin
        case ($urandom_range(0, 19))
          0:       ask(0, strm_pkg::IDX_W'(stim_count - 1));
          1, 2:    ask(strm_pkg::IDX_W'($urandom), strm_pkg::IDX_W'($urandom));
          default: begin
            left = $urandom_range(0, stim_count - 1);
            ask(strm_pkg::IDX_W'(left),
                strm_pkg::IDX_W'($urandom_range(left, stim_count - 1)));
          end
        endcase
      end
      if (set_no == big_at || $urandom_range(0, 3) == 0) drain();
    end

    // Wind down: every answer in, the engine idle, then a short settle period.
    start <= 1'b0;
    do @(posedge clk); while (rmq.pending_answers.size() != 0 || busy);
    repeat (8) @(posedge clk);
    if (rmq.errors == 0 && rmq.pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/strm_pkg.sv
hdl/strm_ram.sv
hdl/sparse_table_range_min_top.sv
tb/tb.sv
